>>> sv/bis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and sizes for the binary insertion sorter and its cells.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int CAPACITY     = 32;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  // one input request
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] payload;
    logic               last_item;
  } item_t;

  // one result request
  typedef struct packed {
    logic signed [31:0] sorted_key;
    logic signed [31:0] sorted_payload;
    logic               end_of_list;
    logic               overflow;
  } result_t;

  // record held in one cell
  typedef struct packed {
    logic                           valid;
    logic signed [KEY_BITS-1:0]     key;
    logic signed [PAYLOAD_BITS-1:0] payload;
  } rec_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the new record, shift the tail up
    logic shift;   // move every record one cell toward cell 0
  } cell_ctrl_t;

endpackage

>>> sv/binary_insertion_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_insertion_sorter
// Stable ascending sort of a list of (key, payload) records in a chain of
// compare-and-shift cells; the list is emitted in order after its last record.
// ----------------------------------------------------------------------------
//   channel  payload             handshake              direction
//   item     bis_pkg::item_t     item_valid/item_stall  in
//   result   bis_pkg::result_t   result_valid/result_stall  out
//
// A record is inserted in the cycle it is accepted: one request per cycle
// while a list is collected, set by the single compare-and-shift step of the
// cell chain. After the last record the chain drains from cell 0, one result
// per cycle; item_stall is high until the final result is taken, and at most
// CAPACITY records of a list are held. Result stalls hold the chain. Reset
// empties the chain and clears the count and the drop flag.
// ----------------------------------------------------------------------------
module binary_insertion_sorter (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bis_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output bis_pkg::result_t result
);

  typedef enum logic {S_FILL, S_DRAIN} state_t;

  state_t                    state;
  logic [bis_pkg::CNT_W-1:0] count;
  logic                      dropped;

  logic                item_acc;
  logic                result_acc;
  logic                full;
  logic                end_of_list;
  bis_pkg::cell_ctrl_t ctrl;
  bis_pkg::rec_t       new_rec;
  bis_pkg::rec_t       recs [bis_pkg::CAPACITY];
  logic                gts  [bis_pkg::CAPACITY];

  // handshakes
  assign item_stall   = (state == S_DRAIN);
  assign result_valid = (state == S_DRAIN);
  assign item_acc     = item_valid && !item_stall;
  assign result_acc   = result_valid && !result_stall;
  assign full         = (count == bis_pkg::CNT_W'(bis_pkg::CAPACITY));

  // broadcast record, narrowed to the stored widths
  assign new_rec.valid   = 1'b1;
  assign new_rec.key     = item.key[bis_pkg::KEY_BITS-1:0];
  assign new_rec.payload = item.payload[bis_pkg::PAYLOAD_BITS-1:0];

  assign ctrl.insert = item_acc && !full;
  assign ctrl.shift  = result_acc;

  // cell chain
  for (genvar i = 0; i < bis_pkg::CAPACITY; i++) begin : g_cell
    bis_pkg::rec_t prev_rec;
    bis_pkg::rec_t next_rec;
    logic          prev_gt;

    if (i == 0) begin : g_first
      assign prev_rec = new_rec;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_rec = recs[i-1];
      assign prev_gt  = gts[i-1];
    end

    if (i == bis_pkg::CAPACITY - 1) begin : g_last
      assign next_rec = '0;
    end else begin : g_inner
      assign next_rec = recs[i+1];
    end

    bis_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .new_rec  (new_rec),
      .prev_rec (prev_rec),
      .prev_gt  (prev_gt),
      .next_rec (next_rec),
      .rec      (recs[i]),
      .gt       (gts[i])
    );
  end

  // result from the head of the chain
  assign end_of_list           = !recs[1].valid;
  assign result.sorted_key     = 32'(recs[0].key);
  assign result.sorted_payload = 32'(recs[0].payload);
  assign result.end_of_list    = end_of_list;
  assign result.overflow       = dropped;

  // list control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FILL;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        S_FILL: begin
          if (item_acc) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (item.last_item) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (result_acc && end_of_list) begin
            state   <= S_FILL;
            count   <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= S_FILL;
        end
      endcase
    end
  end

endmodule

>>> sv/bis_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_cell
// One compare-and-shift cell of the sorting chain: holds one record, compares
// it to the broadcast record and takes its own, a neighbor's or the new record.
// ----------------------------------------------------------------------------
module bis_cell (
  input  logic                clk,
  input  logic                rst,
  input  bis_pkg::cell_ctrl_t ctrl,
  input  bis_pkg::rec_t       new_rec,
  input  bis_pkg::rec_t       prev_rec,
  input  logic                prev_gt,
  input  bis_pkg::rec_t       next_rec,
  output bis_pkg::rec_t       rec,
  output logic                gt
);

  bis_pkg::rec_t rec_next;

  // empty cells count as greater, so the new record lands at the upper bound
  assign gt = !rec.valid || (rec.key > new_rec.key);

  // next record
  always_comb begin
    rec_next = rec;
    if (ctrl.shift) begin
      rec_next = next_rec;
    end else if (ctrl.insert && gt) begin
      rec_next = prev_gt ? prev_rec : new_rec;
    end
  end

  // record register, only the valid bit is reset
  always_ff @(posedge clk) begin
    rec.key     <= rec_next.key;
    rec.payload <= rec_next.payload;
    if (rst) begin
      rec.valid <= 1'b0;
    end else begin
      rec.valid <= rec_next.valid;
    end
  end

endmodule

>>> sim/bis_sort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_sort_checker
// Watches both channels of the binary insertion sorter. Every accepted record
// within CAPACITY joins a private sorted list; on a list's end the expected
// sorted run is queued and each accepted result is compared field by field.
// ----------------------------------------------------------------------------
module bis_sort_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  bis_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  bis_pkg::result_t result,
  output int               mismatches,
  output int               waiting,
  output int               lists_done,
  output int               results_seen
);

  localparam int MAX_PRINTED = 40;

  // records of the list being collected, kept in ascending key order
  logic signed [31:0] held_key     [bis_pkg::CAPACITY];
  logic signed [31:0] held_payload [bis_pkg::CAPACITY];
  int                 held_count;
  logic               dropped;

  // sorted results still owed by the block, oldest first
  bis_pkg::result_t sorted_run_q[$];

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // insert after every equal key, emit the whole run on the last record
  function automatic void add_record(input bis_pkg::item_t r);
    logic signed [bis_pkg::KEY_BITS-1:0]     key_trim;
    logic signed [bis_pkg::PAYLOAD_BITS-1:0] payload_trim;
    logic signed [31:0]                      k;
    logic signed [31:0]                      p;
    int                                      pos;
    bis_pkg::result_t                        res;
    key_trim     = r.key[bis_pkg::KEY_BITS-1:0];
    payload_trim = r.payload[bis_pkg::PAYLOAD_BITS-1:0];
    k = key_trim;
    p = payload_trim;
    if (held_count < bis_pkg::CAPACITY) begin
      pos = held_count;
      while (pos > 0 && held_key[pos-1] > k) begin
        held_key[pos]     = held_key[pos-1];
        held_payload[pos] = held_payload[pos-1];
        pos--;
      end
      held_key[pos]     = k;
      held_payload[pos] = p;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (r.last_item) begin
      for (int i = 0; i < held_count; i++) begin
        res.sorted_key     = held_key[i];
        res.sorted_payload = held_payload[i];
        res.end_of_list    = (i == held_count - 1);
        res.overflow       = dropped;
        sorted_run_q.push_back(res);
      end
      held_count = 0;
      dropped    = 1'b0;
      lists_done++;
    end
  endfunction

  task automatic check_result(input bis_pkg::result_t got);
    bis_pkg::result_t want;
    results_seen++;
    if (sorted_run_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: key %0d payload %0d",
                                got.sorted_key, got.sorted_payload));
    end else begin
      want = sorted_run_q.pop_front();
      if (got.sorted_key !== want.sorted_key)
        report_mismatch($sformatf("sorted_key %0d, expected %0d",
                                  got.sorted_key, want.sorted_key));
      if (got.sorted_payload !== want.sorted_payload)
        report_mismatch($sformatf("sorted_payload %0d, expected %0d",
                                  got.sorted_payload, want.sorted_payload));
      if (got.end_of_list !== want.end_of_list)
        report_mismatch($sformatf("end_of_list %b, expected %b",
                                  got.end_of_list, want.end_of_list));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("overflow %b, expected %b",
                                  got.overflow, want.overflow));
    end
  endtask

  // sample both handshakes at each edge
  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      dropped    = 1'b0;
      sorted_run_q.delete();
      mismatches   = 0;
      lists_done   = 0;
      results_seen = 0;
      waiting     <= 0;
    end else begin
      if (item_valid && !item_stall) add_record(item);
      if (result_valid && !result_stall) check_result(result);
      waiting <= sorted_run_q.size();
    end
  end

endmodule

>>> sim/tb_binary_insertion_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_insertion_sorter
// Feeds lists of signed records to the sorter: a directed set of key
// extremes and equal keys, then random lists, some past the store capacity,
// under changing sender gaps and result stalls. The checker judges results.
// ----------------------------------------------------------------------------
module tb_binary_insertion_sorter;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 2 * bis_pkg::CAPACITY + 8;
  localparam int PHASE_ITEMS  = 35;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  bis_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall = 1'b0;
  bis_pkg::result_t result;

  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int requests_sent = 0;
  int cycle_count   = 0;
  int mismatches;
  int waiting;
  int lists_done;
  int results_seen;

  binary_insertion_sorter i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  bis_sort_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .waiting      (waiting),
    .lists_done   (lists_done),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bis_pkg::item_t record_of(input logic [31:0] k, input logic [31:0] p,
                                               input logic last);
    bis_pkg::item_t r;
    r.key       = k;
    r.payload   = p;
    r.last_item = last;
    return r;
  endfunction

  // keys often drawn from a narrow range so that equal keys are common
  function automatic bis_pkg::item_t random_record(input logic last);
    logic [31:0] k;
    k = $urandom;
    if ($urandom_range(2) == 0) k = $urandom_range(7) - 4;
    return record_of(k, $urandom, last);
  endfunction

  // one request, with a random gap in front
  task automatic send_request(input bis_pkg::item_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= r;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_list(input int len);
    for (int i = 0; i < len; i++) send_request(random_record(i == len - 1));
  endtask

  // hold the sender until every sorted result has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  initial begin : stimulus
    int phase_items;
    int len;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // single-record list at the key and payload extremes
    send_request(record_of(32'h8000_0000, 32'h7fff_ffff, 1'b1));
    // extremes, equal keys at both ends and in the middle
    send_request(record_of(32'h7fff_ffff, 32'h8000_0000, 1'b0));
    send_request(record_of(32'h8000_0000, 32'h0000_0000, 1'b0));
    send_request(record_of(32'h0000_0000, 32'hffff_ffff, 1'b0));
    send_request(record_of(32'hffff_ffff, 32'h0000_0001, 1'b0));
    send_request(record_of(32'd5, 32'd100, 1'b0));
    send_request(record_of(32'd5, 32'd101, 1'b0));
    send_request(record_of(32'd5, 32'd102, 1'b0));
    send_request(record_of(32'h8000_0000, 32'd1, 1'b0));
    send_request(record_of(32'h7fff_ffff, 32'd2, 1'b0));
    send_request(record_of(32'h0000_0000, 32'd3, 1'b1));
    // descending keys, each lands at the front
    send_request(record_of(32'd4, 32'h5555_5555, 1'b0));
    send_request(record_of(32'd3, 32'haaaa_aaaa, 1'b0));
    send_request(record_of(32'd2, 32'h0f0f_0f0f, 1'b0));
    send_request(record_of(32'd1, 32'hf0f0_f0f0, 1'b1));
    wait_drained();

    // random lists under three idle mixes, one long list per phase
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 9;
          out_idle_pct = 72;
          len          = bis_pkg::CAPACITY + 1;
        end
        1: begin
          in_idle_pct  = 72;
          out_idle_pct = 9;
          len          = bis_pkg::CAPACITY;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
          len          = bis_pkg::CAPACITY + 5;
        end
      endcase
      send_list(len);
      wait_drained();
      phase_items = len;
      while (phase_items < PHASE_ITEMS) begin
        len = $urandom_range(1, 10);
        send_list(len);
        phase_items += len;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d requests in %0d lists, checked %0d sorted results",
             requests_sent, lists_done, results_seen);
    $display("covered key extremes, equal keys, full and overflowing store, mixed stalls");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
